// ===== rtl/vt52_pkg.sv =====
`timescale 1ns / 1ps

package vt52_pkg;

  // Framing bytes and parameter window
  localparam logic [7:0] ESC_BYTE   = 8'd27;
  localparam logic [7:0] PARAM_BASE = 8'd32;
  localparam logic [7:0] PARAM_MAX  = 8'd127;
  localparam logic [7:0] CHAR_Y     = 8'h59;
  localparam logic [7:0] CHAR_LO_B  = 8'h62;
  localparam logic [7:0] CHAR_LO_C  = 8'h63;

  // Action codes
  localparam logic [4:0] ACT_NONE  = 5'd0;
  localparam logic [4:0] ACT_TEXT  = 5'd1;
  localparam logic [4:0] ACT_UP    = 5'd2;
  localparam logic [4:0] ACT_DOWN  = 5'd3;
  localparam logic [4:0] ACT_RIGHT = 5'd4;
  localparam logic [4:0] ACT_LEFT  = 5'd5;
  localparam logic [4:0] ACT_CLR   = 5'd6;
  localparam logic [4:0] ACT_HOME  = 5'd7;
  localparam logic [4:0] ACT_RLF   = 5'd8;
  localparam logic [4:0] ACT_ESC_J = 5'd9;
  localparam logic [4:0] ACT_ESC_K = 5'd10;
  localparam logic [4:0] ACT_ESC_L = 5'd11;
  localparam logic [4:0] ACT_ESC_M = 5'd12;
  localparam logic [4:0] ACT_CUP   = 5'd13;
  localparam logic [4:0] ACT_ESC_Z = 5'd14;
  localparam logic [4:0] ACT_FG    = 5'd15;
  localparam logic [4:0] ACT_BG    = 5'd16;
  localparam logic [4:0] ACT_LO_D  = 5'd17;
  localparam logic [4:0] ACT_LO_E  = 5'd18;
  localparam logic [4:0] ACT_LO_F  = 5'd19;
  localparam logic [4:0] ACT_LO_J  = 5'd20;
  localparam logic [4:0] ACT_LO_K  = 5'd21;
  localparam logic [4:0] ACT_LO_L  = 5'd22;
  localparam logic [4:0] ACT_LO_O  = 5'd23;
  localparam logic [4:0] ACT_LO_P  = 5'd24;
  localparam logic [4:0] ACT_LO_Q  = 5'd25;
  localparam logic [4:0] ACT_LO_V  = 5'd26;
  localparam logic [4:0] ACT_LO_W  = 5'd27;
  localparam logic [4:0] ACT_ANSI  = 5'd28;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_START  = 2'd1,
    MODE_PARAM  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_Y    = 2'd1,
    KIND_B    = 2'd2,
    KIND_C    = 2'd3
  } kind_t;

  // Decoder state carried between items
  typedef struct packed {
    mode_t      mode;
    kind_t      kind;
    logic [7:0] row_byte;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic [4:0] action;
    logic [7:0] text_byte;
    logic [6:0] param_row;
    logic [6:0] param_col;
  } result_t;

  // Map a plain escape letter to its action code
  function automatic logic [4:0] escape_code(input logic [7:0] c);
    logic [4:0] code;
    unique case (c)
      8'h41:   code = ACT_UP;     // A
      8'h42:   code = ACT_DOWN;   // B
      8'h43:   code = ACT_RIGHT;  // C
      8'h44:   code = ACT_LEFT;   // D
      8'h45:   code = ACT_CLR;    // E
      8'h48:   code = ACT_HOME;   // H
      8'h49:   code = ACT_RLF;    // I
      8'h4A:   code = ACT_ESC_J;
      8'h4B:   code = ACT_ESC_K;
      8'h4C:   code = ACT_ESC_L;
      8'h4D:   code = ACT_ESC_M;
      8'h5A:   code = ACT_ESC_Z;
      8'h64:   code = ACT_LO_D;
      8'h65:   code = ACT_LO_E;
      8'h66:   code = ACT_LO_F;
      8'h6A:   code = ACT_LO_J;
      8'h6B:   code = ACT_LO_K;
      8'h6C:   code = ACT_LO_L;
      8'h6F:   code = ACT_LO_O;
      8'h70:   code = ACT_LO_P;
      8'h71:   code = ACT_LO_Q;
      8'h76:   code = ACT_LO_V;
      8'h77:   code = ACT_LO_W;
      8'h3C:   code = ACT_ANSI;   // <
      default: code = ACT_NONE;
    endcase
    return code;
  endfunction

  function automatic logic param_ok(input logic [7:0] b);
    return (b >= PARAM_BASE) && (b <= PARAM_MAX);
  endfunction

endpackage

// ===== rtl/vt52_decode.sv =====
`timescale 1ns / 1ps

module vt52_decode
  import vt52_pkg::*;
(
  input  dec_state_t cur,
  input  logic [7:0] rx_byte,
  output dec_state_t nxt,
  output result_t    res
);

  logic [7:0] row_off;
  logic [7:0] col_off;

  assign row_off = cur.row_byte - PARAM_BASE;
  assign col_off = rx_byte - PARAM_BASE;

  // Next decoder state
  always_comb begin
    nxt = cur;
    unique case (cur.mode)
      MODE_START: begin
        nxt.mode = MODE_NORMAL;
        if (rx_byte == CHAR_Y) begin
          nxt.kind     = KIND_Y;
          nxt.row_byte = 8'd0;
          nxt.mode     = MODE_PARAM;
        end else if (rx_byte == CHAR_LO_B) begin
          nxt.kind = KIND_B;
          nxt.mode = MODE_PARAM;
        end else if (rx_byte == CHAR_LO_C) begin
          nxt.kind = KIND_C;
          nxt.mode = MODE_PARAM;
        end
      end
      MODE_PARAM: begin
        unique case (cur.kind)
          KIND_Y: begin
            // a zero row byte leaves the row unread
            if (cur.row_byte == 8'd0) begin
              nxt.row_byte = rx_byte;
            end else begin
              nxt.mode = MODE_NORMAL;
            end
          end
          KIND_B, KIND_C: begin
            // wait until a usable colour byte arrives
            if (param_ok(rx_byte)) begin
              nxt.mode = MODE_NORMAL;
            end
          end
          default: nxt.mode = MODE_NORMAL;
        endcase
      end
      default: begin
        nxt.mode = (rx_byte == ESC_BYTE) ? MODE_START : MODE_NORMAL;
      end
    endcase
  end

  // Result for this item
  always_comb begin
    res = '0;
    unique case (cur.mode)
      MODE_START: begin
        if (rx_byte != CHAR_Y && rx_byte != CHAR_LO_B && rx_byte != CHAR_LO_C) begin
          res.action = escape_code(rx_byte);
        end
      end
      MODE_PARAM: begin
        unique case (cur.kind)
          KIND_Y: begin
            if (cur.row_byte != 8'd0 && param_ok(cur.row_byte) && param_ok(rx_byte)) begin
              res.action    = ACT_CUP;
              res.param_row = row_off[6:0];
              res.param_col = col_off[6:0];
            end
          end
          KIND_B, KIND_C: begin
            if (param_ok(rx_byte)) begin
              res.action    = (cur.kind == KIND_B) ? ACT_FG : ACT_BG;
              res.param_row = {3'd0, col_off[3:0]};
            end
          end
          default: res = '0;
        endcase
      end
      default: begin
        if (rx_byte != ESC_BYTE) begin
          res.action    = ACT_TEXT;
          res.text_byte = rx_byte;
        end
      end
    endcase
  end

endmodule

// ===== rtl/vt52_escape_decoder_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_rx_byte[7:0]
// out_     output     out_valid / out_stall out_action[4:0], out_text_byte[7:0],
//                                           out_param_row[6:0], out_param_col[6:0]
//
// One item per cycle while in_stall is low; each accepted item yields one registered result.
// The decode of one byte is one pass of combinational logic from the parse
// state registers and the input byte to the result register.
// Synchronous active-low reset returns the parser to normal text mode.
// A one-entry skid stage behind the result register absorbs one item while
// out_stall is high; in_stall rises only when that entry is occupied.

module vt52_escape_decoder_top
  import vt52_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_action,
  output logic [7:0] out_text_byte,
  output logic [6:0] out_param_row,
  output logic [6:0] out_param_col
);

  dec_state_t state_r, state_nxt;
  result_t    dec_res;
  result_t    out_data_r, skid_data_r;
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  logic       out_load, skid_load, accept, out_free;

  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;

  vt52_decode u_decode (
    .cur     (state_r),
    .rx_byte (in_rx_byte),
    .nxt     (state_nxt),
    .res     (dec_res)
  );

  // Advance parse state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: MODE_NORMAL, kind: KIND_NONE, row_byte: 8'd0};
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Steer results into the output register or hold them in the skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    skid_load      = 1'b0;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
        out_load       = 1'b1;
      end else begin
        out_valid_nxt = accept;
        out_load      = accept;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= skid_valid_r ? skid_data_r : dec_res;
    end
    if (skid_load) begin
      skid_data_r <= dec_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_data_r.action;
  assign out_text_byte = out_data_r.text_byte;
  assign out_param_row = out_data_r.param_row;
  assign out_param_col = out_data_r.param_col;

  // The skid entry is only ever filled behind a stalled result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied with empty output register");

  // ESC in normal mode moves the parser to the escape-start state
  a_esc_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && state_r.mode == MODE_NORMAL && in_rx_byte == ESC_BYTE
    |=> state_r.mode == MODE_START)
    else $error("ESC did not open an escape sequence");

  // Text byte is zero unless the result prints text
  a_text_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.action != ACT_TEXT |-> out_data_r.text_byte == 8'd0)
    else $error("text byte set on a non-text result");

  // Column operand appears only with cursor addressing
  a_col_only_cup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.action != ACT_CUP |-> out_data_r.param_col == 7'd0)
    else $error("column operand set on a non-cursor result");

endmodule
